/* rtl/eqd_pkg.sv */
// Shared constants and the CORDIC arctangent table for the equirectangular distance block.
package eqd_pkg;

   localparam logic [63:0] P62          = 64'hC90FDAA22168C235;
   localparam logic [63:0] ANG_MUL_W    = (P62 >> 4) / 64'd36000000;
   localparam logic [63:0] DIST_MUL_W   = (P62 >> 14) / 64'd180000;
   localparam logic [63:0] PI_Q30_W     = P62 >> 32;
   localparam logic [63:0] HALF_PI_W    = P62 >> 33;

   localparam logic [34:0] ANG_MUL      = ANG_MUL_W[34:0];
   localparam logic [32:0] DIST_MUL     = DIST_MUL_W[32:0];
   localparam logic [33:0] PI_Q30       = PI_Q30_W[33:0];
   localparam logic [32:0] HALF_PI_Q30  = HALF_PI_W[32:0];
   localparam logic [33:0] CORDIC_GAIN  = 34'h026DD3B6A;

   localparam logic [23:0] RADIUS_RST   = 24'd6371229;
   localparam int          COS_ITER_DEF = 24;
   localparam int          SQRT_BITS    = 58;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:  a = 32'h3243F6A8;
         5'd1:  a = 32'h1DAC6705;
         5'd2:  a = 32'h0FADBAFC;
         5'd3:  a = 32'h07F56EA6;
         5'd4:  a = 32'h03FEAB76;
         5'd5:  a = 32'h01FFD55B;
         5'd6:  a = 32'h00FFFAAA;
         5'd7:  a = 32'h007FFF55;
         5'd8:  a = 32'h003FFFEA;
         5'd9:  a = 32'h001FFFFD;
         5'd10: a = 32'h000FFFFF;
         5'd11: a = 32'h0007FFFF;
         5'd12: a = 32'h0003FFFF;
         5'd13: a = 32'h0001FFFF;
         5'd14: a = 32'h0000FFFF;
         5'd15: a = 32'h00007FFF;
         5'd16: a = 32'h00003FFF;
         5'd17: a = 32'h00001FFF;
         5'd18: a = 32'h00000FFF;
         5'd19: a = 32'h000007FF;
         5'd20: a = 32'h000003FF;
         5'd21: a = 32'h000001FF;
         5'd22: a = 32'h000000FF;
         5'd23: a = 32'h0000007F;
         5'd24: a = 32'h0000003F;
         5'd25: a = 32'h0000001F;
         5'd26: a = 32'h0000000F;
         5'd27: a = 32'h00000008;
         5'd28: a = 32'h00000004;
         5'd29: a = 32'h00000002;
         5'd30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

/* rtl/equirectangular_distance.sv */
// Throughput: one beat per cycle; every stage advances together when the output register
// is empty or being taken, so a stall holds the whole pipeline.
// Stage count is set by one CORDIC iteration and one root bit per stage.
// Reset: clears all valid bits and loads the default earth radius; no clearing pass.
// Top level of the equirectangular distance pipeline.
module equirectangular_distance #(
   parameter int COS_ITERATIONS = eqd_pkg::COS_ITER_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // lat_a[24:0], lon_a[50:25], lat_b[75:51], lon_b[101:76]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // dist_cm[32:0]
   input  logic         csr_we,
   input  logic [23:0]  csr_wdata
);

   localparam int N   = COS_ITERATIONS;
   localparam int SB  = eqd_pkg::SQRT_BITS;
   localparam int LAT = N + 67;

   logic           adv;
   logic [LAT-1:0] vld_ff;

   logic [23:0] radius_ff;
   logic [56:0] g_ff;

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         radius_ff <= eqd_pkg::RADIUS_RST;
      end else begin
         if (adv) vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
         if (csr_we) radius_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      g_ff <= 57'(radius_ff) * 57'(eqd_pkg::DIST_MUL);
   end

   // input stage
   logic [24:0] lat_a, lat_b;
   logic [25:0] lon_a, lon_b;
   logic [25:0] lat_sum, lat_dif;
   logic [26:0] lon_dif;
   logic [25:0] smag_in, dlat_in;
   logic [26:0] dlon_in;
   logic [25:0] smag_ff, dlat0_ff, dlat1_ff;
   logic [26:0] dlon0_ff, dlon1_ff;
   logic [60:0] prod_ff;

   assign lat_a   = req_tdata[24:0];
   assign lon_a   = req_tdata[50:25];
   assign lat_b   = req_tdata[75:51];
   assign lon_b   = req_tdata[101:76];
   assign lat_sum = {lat_a[24], lat_a} + {lat_b[24], lat_b};
   assign lat_dif = {lat_b[24], lat_b} - {lat_a[24], lat_a};
   assign lon_dif = {lon_b[25], lon_b} - {lon_a[25], lon_a};
   assign smag_in = lat_sum[25] ? (~lat_sum + 26'd1) : lat_sum;
   assign dlat_in = lat_dif[25] ? (~lat_dif + 26'd1) : lat_dif;
   assign dlon_in = lon_dif[26] ? (~lon_dif + 27'd1) : lon_dif;

   always_ff @(posedge clock) begin
      if (adv) begin
         smag_ff  <= smag_in;
         dlat0_ff <= dlat_in;
         dlon0_ff <= dlon_in;
         prod_ff  <= 61'(smag_ff) * 61'(eqd_pkg::ANG_MUL);
         dlat1_ff <= dlat0_ff;
         dlon1_ff <= dlon0_ff;
      end
   end

   // angle rounding and fold, then CORDIC
   logic [60:0]        prod_rnd;
   logic [32:0]        theta;
   logic signed [33:0] z0_in;
   logic signed [33:0] cx_ff [0:N];
   logic signed [33:0] cy_ff [0:N];
   logic signed [33:0] cz_ff [0:N];
   logic [26:0]        cdlon_ff [0:N];
   logic [25:0]        cdlat_ff [0:N];

   assign prod_rnd = prod_ff + 61'(1 << 27);
   assign theta    = prod_rnd[60:28];
   assign z0_in    = (theta > eqd_pkg::HALF_PI_Q30) ? (eqd_pkg::PI_Q30 - {1'b0, theta})
                                                    : {1'b0, theta};

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0]    <= eqd_pkg::CORDIC_GAIN;
         cy_ff[0]    <= '0;
         cz_ff[0]    <= z0_in;
         cdlon_ff[0] <= dlon1_ff;
         cdlat_ff[0] <= dlat1_ff;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cordic
      logic signed [33:0] xs, ys, at;
      assign xs = cx_ff[i] >>> i;
      assign ys = cy_ff[i] >>> i;
      assign at = 34'(eqd_pkg::atan_q30(5'(i)));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!cz_ff[i][33]) begin
               cx_ff[i+1] <= cx_ff[i] - ys;
               cy_ff[i+1] <= cy_ff[i] + xs;
               cz_ff[i+1] <= cz_ff[i] - at;
            end else begin
               cx_ff[i+1] <= cx_ff[i] + ys;
               cy_ff[i+1] <= cy_ff[i] - xs;
               cz_ff[i+1] <= cz_ff[i] + at;
            end
            cdlon_ff[i+1] <= cdlon_ff[i];
            cdlat_ff[i+1] <= cdlat_ff[i];
         end
      end
   end

   // scaled axes, squares and their sum
   logic [33:0]  xmag;
   logic [57:0]  u_ff;
   logic [51:0]  dl2_ff, dl2b_ff;
   logic [57:0]  p11_ff, p10_ff, p00_ff;
   logic [115:0] sum_ff;

   assign xmag = cx_ff[N][33] ? (~cx_ff[N] + 34'd1) : cx_ff[N];

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff    <= 58'(cdlon_ff[N]) * 58'(xmag[30:0]);
         dl2_ff  <= 52'(cdlat_ff[N]) * 52'(cdlat_ff[N]);
         p11_ff  <= 58'(u_ff[57:29]) * 58'(u_ff[57:29]);
         p10_ff  <= 58'(u_ff[57:29]) * 58'(u_ff[28:0]);
         p00_ff  <= 58'(u_ff[28:0]) * 58'(u_ff[28:0]);
         dl2b_ff <= dl2_ff;
         sum_ff  <= (116'(p11_ff) << 58) + (116'(p10_ff) << 30) + 116'(p00_ff)
                    + (116'(dl2b_ff) << 60);
      end
   end

   // square root, one bit per stage
   logic [115:0] rem_ff  [1:SB];
   logic [57:0]  root_ff [1:SB];

   for (genvar k = 0; k < SB; k++) begin : g_sqrt
      localparam int B = SB - 1 - k;
      logic [115:0] rem_src;
      logic [57:0]  root_src;
      logic [117:0] trial, rem_x;
      if (k == 0) begin : g_first
         assign rem_src  = sum_ff;
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[k];
         assign root_src = root_ff[k];
      end
      assign trial = (118'(root_src) << (B + 1)) | (118'(1) << (2 * B));
      assign rem_x = 118'(rem_src);
      always_ff @(posedge clock) begin
         if (adv) begin
            if (trial <= rem_x) begin
               rem_ff[k+1]  <= 116'(rem_x - trial);
               root_ff[k+1] <= root_src | (58'(1) << B);
            end else begin
               rem_ff[k+1]  <= rem_src;
               root_ff[k+1] <= root_src;
            end
         end
      end
   end

   // distance scaling, rounding and saturation
   logic [57:0]  h;
   logic [57:0]  m00_ff, m01_ff, m10_ff, m11_ff;
   logic [115:0] lo_ff, hi_ff, tot;
   logic [37:0]  d_raw;
   logic [32:0]  dist_ff;

   assign h     = root_ff[SB];
   assign tot   = lo_ff + hi_ff;
   assign d_raw = tot[115:78];

   always_ff @(posedge clock) begin
      if (adv) begin
         m00_ff  <= 58'(h[28:0])  * 58'(g_ff[28:0]);
         m01_ff  <= 58'(h[28:0])  * 58'(g_ff[56:29]);
         m10_ff  <= 58'(h[57:29]) * 58'(g_ff[28:0]);
         m11_ff  <= 58'(h[57:29]) * 58'(g_ff[56:29]);
         lo_ff   <= 116'(m00_ff) + (116'(m01_ff) << 29) + (116'(1) << 77);
         hi_ff   <= (116'(m10_ff) << 29) + (116'(m11_ff) << 58);
         dist_ff <= (|d_raw[37:33]) ? '1 : d_raw[32:0];
      end
   end

   assign rsp_tdata = {7'd0, dist_ff};

endmodule
